@@ design/crc32sbc_pkg.sv @@
// Package for the CRC-32 checker with single-bit error location.
// Holds sizes, CRC constants, status codes, shared structs and the CRC shift.
// No dependencies.
package crc32sbc_pkg;

   // frame bound and derived widths
   localparam int MAX_FRAME_BYTES = 2048;
   localparam int COUNT_W         = $clog2(MAX_FRAME_BYTES + 2);

   // word field widths
   localparam int DATA_W     = 8;
   localparam int STATUS_W   = 3;
   localparam int BYTE_IDX_W = 11;
   localparam int BIT_IDX_W  = 3;

   // reflected CRC-32
   localparam logic [31:0] CRC_POLY = 32'hEDB88320;
   localparam logic [31:0] CRC_ONES = 32'hFFFFFFFF;

   // result status codes
   typedef enum logic [STATUS_W-1:0] {
      STAT_OK        = 3'd0,
      STAT_CORRECTED = 3'd1,
      STAT_UNCORR    = 3'd2,
      STAT_SHORT     = 3'd3,
      STAT_LONG      = 3'd4
   } status_type;

   // command into the search engine
   typedef struct packed {
      logic               start;
      logic [31:0]        syndrome;
      logic [COUNT_W-1:0] last_pos;   // index of the last data byte
   } search_cmd_type;

   // answer from the search engine
   typedef struct packed {
      logic                  done;
      logic                  found;
      logic [COUNT_W-1:0]    byte_idx;
      logic [BIT_IDX_W-1:0]  bit_idx;
   } search_res_type;

   // one step of the reflected CRC register
   function automatic logic [31:0] crc_shift(input logic [31:0] v);
      crc_shift = (v >> 1) ^ ({32{v[0]}} & CRC_POLY);
   endfunction

endpackage

@@ design/crc32sbc_if.sv @@
// Valid/ready channel interfaces for the request and response words.
// Depends on crc32sbc_pkg for field widths.
interface crc32sbc_req_if;
   logic                              valid;
   logic                              ready;
   logic [crc32sbc_pkg::DATA_W-1:0]   data_byte;
   logic                              last;

   modport source (output valid, output data_byte, output last, input ready);
   modport sink   (input valid, input data_byte, input last, output ready);
endinterface

interface crc32sbc_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic [crc32sbc_pkg::STATUS_W-1:0]    status;
   logic [crc32sbc_pkg::BYTE_IDX_W-1:0]  error_byte;
   logic [crc32sbc_pkg::BIT_IDX_W-1:0]   error_bit;

   modport source (output valid, output status, output error_byte, output error_bit,
                   input ready);
   modport sink   (input valid, input status, input error_byte, input error_bit,
                   output ready);
endinterface

@@ design/crc32_check_single_bit_correct_core.sv @@
// Top level of the CRC-32 frame checker with single-bit error location.
// Depends on crc32sbc_pkg, crc32sbc_if.sv and crc32sbc_search.
//
//  channel   dir  handshake      word
//  req_chan  in   valid/ready    data_byte[7:0], last
//  rsp_chan  out  valid/ready    status[2:0], error_byte[10:0], error_bit[2:0]
//
// A byte that pushes a data byte into the CRC goes through ST_CRC (bit-serial CRC
// register, one shift per cycle); the first four bytes of a frame and bytes past
// the bound skip it. After the last byte ST_EVAL sets the verdict and ST_POST
// posts it, with a bit-serial search run between them on a mismatch with data.
// Reset is synchronous, active high; the frame state returns to its reset value.
// A waiting response word does not block intake; only a second result waits for it.
module crc32_check_single_bit_correct_core (
   input  logic                  clock,
   input  logic                  reset,
   crc32sbc_req_if.sink          req_chan,
   crc32sbc_rsp_if.source        rsp_chan
);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_CRC    = 5'b00010,
      ST_EVAL   = 5'b00100,
      ST_SEARCH = 5'b01000,
      ST_POST   = 5'b10000
   } state_type;

   state_type                                state_ff, state_in;
   logic [31:0]                              crc_ff, crc_in;
   logic [31:0]                              tail_ff, tail_in;
   logic [crc32sbc_pkg::COUNT_W-1:0]         count_ff, count_in;
   logic [crc32sbc_pkg::BIT_IDX_W-1:0]       shift_cnt_ff, shift_cnt_in;
   logic                                     last_pend_ff, last_pend_in;
   crc32sbc_pkg::status_type                 res_status_ff, res_status_in;
   logic [crc32sbc_pkg::COUNT_W-1:0]         res_byte_ff, res_byte_in;
   logic [crc32sbc_pkg::BIT_IDX_W-1:0]       res_bit_ff, res_bit_in;
   logic                                     rsp_valid_ff, rsp_valid_in;
   logic [crc32sbc_pkg::STATUS_W-1:0]        rsp_status_ff, rsp_status_in;
   logic [crc32sbc_pkg::BYTE_IDX_W-1:0]      rsp_byte_ff, rsp_byte_in;
   logic [crc32sbc_pkg::BIT_IDX_W-1:0]       rsp_bit_ff, rsp_bit_in;

   logic                                     accept;
   logic                                     in_range;
   logic                                     feeds_crc;
   logic                                     load_rsp;
   logic [31:0]                              syndrome;
   crc32sbc_pkg::search_cmd_type             search_cmd;
   crc32sbc_pkg::search_res_type             search_res;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;
   assign in_range  = (count_ff <= crc32sbc_pkg::COUNT_W'(crc32sbc_pkg::MAX_FRAME_BYTES));
   assign feeds_crc = in_range && (count_ff >= crc32sbc_pkg::COUNT_W'(4));
   assign syndrome  = crc_ff ^ crc32sbc_pkg::CRC_ONES ^ tail_ff;
   assign load_rsp  = (state_ff == ST_POST) && (!rsp_valid_ff || rsp_chan.ready);

   // frame intake, CRC shifting and result evaluation
   always_comb begin
      state_in      = state_ff;
      crc_in        = crc_ff;
      tail_in       = tail_ff;
      count_in      = count_ff;
      shift_cnt_in  = shift_cnt_ff;
      last_pend_in  = last_pend_ff;
      res_status_in = res_status_ff;
      res_byte_in   = res_byte_ff;
      res_bit_in    = res_bit_ff;
      search_cmd.start    = 1'b0;
      search_cmd.syndrome = syndrome;
      search_cmd.last_pos = count_ff - crc32sbc_pkg::COUNT_W'(5);
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               last_pend_in = req_chan.last;
               if (in_range) begin
                  tail_in  = {req_chan.data_byte, tail_ff[31:8]};
                  count_in = count_ff + 1'b1;
               end
               if (feeds_crc) begin
                  crc_in       = crc_ff ^ {24'h0, tail_ff[7:0]};
                  shift_cnt_in = '0;
                  state_in     = ST_CRC;
               end else if (req_chan.last) begin
                  state_in = ST_EVAL;
               end
            end
         end
         ST_CRC: begin
            crc_in       = crc32sbc_pkg::crc_shift(crc_ff);
            shift_cnt_in = shift_cnt_ff + 1'b1;
            if (shift_cnt_ff == '1) begin
               state_in = last_pend_ff ? ST_EVAL : ST_IDLE;
            end
         end
         ST_EVAL: begin
            res_byte_in = '0;
            res_bit_in  = '0;
            state_in    = ST_POST;
            priority if (!in_range) begin
               res_status_in = crc32sbc_pkg::STAT_LONG;
            end else if (count_ff < crc32sbc_pkg::COUNT_W'(4)) begin
               res_status_in = crc32sbc_pkg::STAT_SHORT;
            end else if (syndrome == '0) begin
               res_status_in = crc32sbc_pkg::STAT_OK;
            end else if (count_ff == crc32sbc_pkg::COUNT_W'(4)) begin
               res_status_in = crc32sbc_pkg::STAT_UNCORR;
            end else begin
               search_cmd.start = 1'b1;
               state_in         = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (search_res.done) begin
               state_in = ST_POST;
               if (search_res.found) begin
                  res_status_in = crc32sbc_pkg::STAT_CORRECTED;
                  res_byte_in   = search_res.byte_idx;
                  res_bit_in    = search_res.bit_idx;
               end else begin
                  res_status_in = crc32sbc_pkg::STAT_UNCORR;
               end
            end
         end
         ST_POST: begin
            if (load_rsp) begin
               crc_in   = crc32sbc_pkg::CRC_ONES;
               tail_in  = '0;
               count_in = '0;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // response register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in = rsp_status_ff;
      rsp_byte_in   = rsp_byte_ff;
      rsp_bit_in    = rsp_bit_ff;
      if (load_rsp) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = res_status_ff;
         rsp_byte_in   = crc32sbc_pkg::BYTE_IDX_W'(res_byte_ff);
         rsp_bit_in    = res_bit_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         crc_ff       <= crc32sbc_pkg::CRC_ONES;
         tail_ff      <= '0;
         count_ff     <= '0;
         shift_cnt_ff <= '0;
         last_pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         crc_ff       <= crc_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         shift_cnt_ff <= shift_cnt_in;
         last_pend_ff <= last_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      res_status_ff <= res_status_in;
      res_byte_ff   <= res_byte_in;
      res_bit_ff    <= res_bit_in;
      rsp_status_ff <= rsp_status_in;
      rsp_byte_ff   <= rsp_byte_in;
      rsp_bit_ff    <= rsp_bit_in;
   end

   crc32sbc_search u_search (
      .clock (clock),
      .reset (reset),
      .cmd   (search_cmd),
      .res   (search_res)
   );

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.status     = rsp_status_ff;
   assign rsp_chan.error_byte = rsp_byte_ff;
   assign rsp_chan.error_bit  = rsp_bit_ff;

`ifndef SYNTHESIS
   // location fields are zero unless a bit was corrected
   a_loc_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != crc32sbc_pkg::STAT_CORRECTED)
         |-> (rsp_byte_ff == '0 && rsp_bit_ff == '0))
      else $error("location set on a word that is not a correction");

   // the search engine only finishes while the FSM waits for it
   a_done_in_search: assert property (@(posedge clock) disable iff (reset)
      search_res.done |-> state_ff == ST_SEARCH)
      else $error("search finished outside the search state");

   // frame state is back at reset value after a result is posted
   a_frame_cleared: assert property (@(posedge clock) disable iff (reset)
      load_rsp |=> (count_ff == '0 && crc_ff == crc32sbc_pkg::CRC_ONES && tail_ff == '0))
      else $error("frame state not cleared after result");
`endif

endmodule

@@ design/crc32sbc_search.sv @@
// Bit-serial single-bit error search: walks the CRC error pattern one shift per cycle.
// Depends on crc32sbc_pkg (crc_shift, search structs).
module crc32sbc_search (
   input  logic                          clock,
   input  logic                          reset,
   input  crc32sbc_pkg::search_cmd_type  cmd,
   output crc32sbc_pkg::search_res_type  res
);

   logic [31:0]                           pattern_ff, pattern_in;
   logic [31:0]                           syn_ff, syn_in;
   logic [crc32sbc_pkg::COUNT_W-1:0]      pos_ff, pos_in;
   logic [crc32sbc_pkg::BIT_IDX_W-1:0]    bit_ff, bit_in;
   logic                                  busy_ff, busy_in;
   logic                                  done_ff, done_in;
   logic                                  found_ff, found_in;
   logic [crc32sbc_pkg::COUNT_W-1:0]      rec_byte_ff, rec_byte_in;
   logic [crc32sbc_pkg::BIT_IDX_W-1:0]    rec_bit_ff, rec_bit_in;
   logic [31:0]                           shifted;

   // Pattern after n shifts of 1 is the syndrome of the bit that is n steps from the end;
   // walking from the last byte down and bit 7 down, the final match is the lowest.
   assign shifted = crc32sbc_pkg::crc_shift(pattern_ff);

   always_comb begin
      pattern_in  = pattern_ff;
      syn_in      = syn_ff;
      pos_in      = pos_ff;
      bit_in      = bit_ff;
      busy_in     = busy_ff;
      done_in     = 1'b0;
      found_in    = found_ff;
      rec_byte_in = rec_byte_ff;
      rec_bit_in  = rec_bit_ff;
      if (cmd.start) begin
         pattern_in = 32'h1;
         syn_in     = cmd.syndrome;
         pos_in     = cmd.last_pos;
         bit_in     = '1;
         busy_in    = 1'b1;
         found_in   = 1'b0;
      end else if (busy_ff) begin
         pattern_in = shifted;
         if (shifted == syn_ff) begin
            found_in    = 1'b1;
            rec_byte_in = pos_ff;
            rec_bit_in  = bit_ff;
         end
         bit_in = bit_ff - 1'b1;
         if (bit_ff == '0) begin
            if (pos_ff == '0) begin
               busy_in = 1'b0;
               done_in = 1'b1;
            end else begin
               pos_in = pos_ff - 1'b1;
            end
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         found_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         found_ff <= found_in;
      end
   end

   // work registers
   always_ff @(posedge clock) begin
      pattern_ff  <= pattern_in;
      syn_ff      <= syn_in;
      pos_ff      <= pos_in;
      bit_ff      <= bit_in;
      rec_byte_ff <= rec_byte_in;
      rec_bit_ff  <= rec_bit_in;
   end

   assign res.done     = done_ff;
   assign res.found    = found_ff;
   assign res.byte_idx = rec_byte_ff;
   assign res.bit_idx  = rec_bit_ff;

endmodule

@@ test/tb.sv @@
// Testbench for crc32_check_single_bit_correct_core: byte-serial CRC-32 frame checks.
// Drives random and hand-built frames and checks each verdict word against a predictor.
// Depends on crc32sbc_pkg, crc32sbc_if.sv and the core.
`timescale 1ns / 100ps

module tb;
   import crc32sbc_pkg::*;

   // frame verdict predictor and expected-verdict queue
   class crc_frame_scoreboard;
      typedef struct {
         status_type             status;
         logic [BYTE_IDX_W-1:0]  err_byte;
         logic [BIT_IDX_W-1:0]   err_bit;
      } verdict_type;

      verdict_type   expected_verdicts[$];
      logic [31:0]   crc_reg;
      logic [31:0]   tail;
      int unsigned   count;
      int            errors;

      function new();
         clear_frame();
         errors = 0;
      endfunction

      // advance the reflected CRC register n bit steps
      static function logic [31:0] crc_steps(logic [31:0] v, int unsigned n);
         int unsigned k;
         for (k = 0; k < n; k++)
            v = (v >> 1) ^ (v[0] ? CRC_POLY : 32'h0);
         return v;
      endfunction

      function void clear_frame();
         crc_reg = CRC_ONES;
         tail    = '0;
         count   = 0;
      endfunction

      // walk data bytes from the last down; last hit kept is the lowest byte
      function verdict_type locate_bit_error(logic [31:0] syndrome, int len);
         verdict_type   v;
         logic [31:0]   pat[8];
         int            idx;
         int            b;
         bit            hit;
         v.status   = STAT_UNCORR;
         v.err_byte = '0;
         v.err_bit  = '0;
         for (b = 0; b < 8; b++)
            pat[b] = crc_steps(32'h1 << b, 8);
         for (idx = len - 1; idx >= 0; idx--) begin
            hit = 0;
            for (b = 0; b < 8; b++) begin
               if (!hit && pat[b] == syndrome) begin
                  hit        = 1;
                  v.status   = STAT_CORRECTED;
                  v.err_byte = BYTE_IDX_W'(idx);
                  v.err_bit  = BIT_IDX_W'(b);
               end
            end
            for (b = 0; b < 8; b++)
               pat[b] = crc_steps(pat[b], 8);
         end
         return v;
      endfunction

      // called for every accepted request word
      function void note_byte(logic [7:0] data, logic lst);
         verdict_type   v;
         logic [31:0]   syndrome;
         if (count <= MAX_FRAME_BYTES) begin
            // a byte enters the CRC only when it drops out of the tail
            if (count >= 4)
               crc_reg = crc_steps(crc_reg ^ {24'h0, tail[7:0]}, 8);
            tail  = {data, tail[31:8]};
            count = count + 1;
         end
         if (!lst)
            return;
         v.status   = STAT_OK;
         v.err_byte = '0;
         v.err_bit  = '0;
         if (count > MAX_FRAME_BYTES)
            v.status = STAT_LONG;
         else if (count < 4)
            v.status = STAT_SHORT;
         else begin
            syndrome = crc_reg ^ CRC_ONES ^ tail;
            if (syndrome != 0)
               v = locate_bit_error(syndrome, int'(count) - 4);
         end
         expected_verdicts.insert(expected_verdicts.size(), v);
         clear_frame();
      endfunction

      task report_mismatch(string msg);
         $display("MISMATCH @%0t: %s", $time, msg);
         errors++;
      endtask

      // called for every accepted response word
      task check_word(logic [STATUS_W-1:0] st, logic [BYTE_IDX_W-1:0] eb,
                      logic [BIT_IDX_W-1:0] ebit);
         verdict_type v;
         if (expected_verdicts.size() == 0) begin
            report_mismatch($sformatf("unexpected word status=%0d byte=%0d bit=%0d",
                                      st, eb, ebit));
            return;
         end
         v = expected_verdicts.pop_front();
         if (st !== v.status)
            report_mismatch($sformatf("status %0d, want %s", st, v.status.name()));
         if (eb !== v.err_byte)
            report_mismatch($sformatf("error_byte %0d, want %0d", eb, v.err_byte));
         if (ebit !== v.err_bit)
            report_mismatch($sformatf("error_bit %0d, want %0d", ebit, v.err_bit));
      endtask

      function int pending();
         return expected_verdicts.size();
      endfunction
   endclass

   logic clock;
   logic reset;

   crc32sbc_req_if req_chan();
   crc32sbc_rsp_if rsp_chan();

   crc32_check_single_bit_correct_core DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   crc_frame_scoreboard sb = new();

   int          send_idle;
   int          recv_idle;
   int          items_sent;
   logic [7:0]  frame_buf[$];

   // clock
   always #10 clock = ~clock;

   // response side: random back-pressure, ready changes on the falling edge
   always @(negedge clock) begin
      rsp_chan.ready <= ($urandom_range(99) >= recv_idle);
   end

   // response side: check on the rising edge
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready)
         sb.check_word(rsp_chan.status, rsp_chan.error_byte, rsp_chan.error_bit);
   end

   // one request word; starts and ends at a falling edge, valid left high
   task send_byte(input logic [7:0] data, input logic lst);
      while ($urandom_range(99) < send_idle) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.data_byte <= data;
      req_chan.last      <= lst;
      @(posedge clock);
      while (!req_chan.ready)
         @(posedge clock);
      sb.note_byte(data, lst);
      items_sent++;
      @(negedge clock);
   endtask

   task send_frame();
      int i;
      for (i = 0; i < frame_buf.size(); i++)
         send_byte(frame_buf[i], i == frame_buf.size() - 1);
   endtask

   // n random data bytes followed by their CRC, low byte first
   task build_frame(input int n);
      logic [31:0] c;
      logic [7:0]  b;
      int          i;
      frame_buf.delete();
      c = CRC_ONES;
      for (i = 0; i < n; i++) begin
         b = 8'($urandom);
         frame_buf.insert(frame_buf.size(), b);
         c = crc_frame_scoreboard::crc_steps(c ^ {24'h0, b}, 8);
      end
      c = c ^ CRC_ONES;
      frame_buf.insert(frame_buf.size(), c[7:0]);
      frame_buf.insert(frame_buf.size(), c[15:8]);
      frame_buf.insert(frame_buf.size(), c[23:16]);
      frame_buf.insert(frame_buf.size(), c[31:24]);
   endtask

   task build_noise(input int n);
      int i;
      frame_buf.delete();
      for (i = 0; i < n; i++)
         frame_buf.insert(frame_buf.size(), 8'($urandom));
   endtask

   task flip_bit(input int idx, input int b);
      frame_buf[idx] = frame_buf[idx] ^ (8'h1 << b);
   endtask

   // hold off the sender until every verdict is back
   task wait_drained();
      req_chan.valid <= 1'b0;
      @(negedge clock);
      while (sb.pending() != 0)
         @(negedge clock);
   endtask

   task random_frame();
      int roll;
      int pick;
      int n;
      roll = $urandom_range(99);
      pick = $urandom_range(99);
      // mostly short frames, a few long ones
      if (pick < 80)
         n = $urandom_range(24);
      else if (pick < 97)
         n = $urandom_range(200, 25);
      else
         n = $urandom_range(600, 201);
      if (roll < 35)
         build_frame(n);
      else if (roll < 70) begin
         build_frame(n);
         if (n > 0)
            flip_bit($urandom_range(n - 1), $urandom_range(7));
      end else if (roll < 78) begin
         // hit in the CRC field rather than in the data
         build_frame(n);
         flip_bit(n + $urandom_range(3), $urandom_range(7));
      end else if (roll < 86) begin
         build_frame(n);
         flip_bit($urandom_range(frame_buf.size() - 1), $urandom_range(7));
         flip_bit($urandom_range(frame_buf.size() - 1), $urandom_range(7));
      end else if (roll < 93)
         build_noise($urandom_range(24, 4));
      else
         build_noise($urandom_range(3, 1));
      send_frame();
   endtask

   task run_random(input int sidle, input int ridle, input int target);
      int start;
      send_idle = sidle;
      recv_idle = ridle;
      start     = items_sent;
      while (items_sent - start < target)
         random_frame();
   endtask

   // main sequence
   initial begin
      clock              = 1'b0;
      reset              = 1'b1;
      req_chan.valid     = 1'b0;
      req_chan.data_byte = '0;
      req_chan.last      = 1'b0;
      rsp_chan.ready     = 1'b0;
      send_idle          = 0;
      recv_idle          = 0;
      items_sent         = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // too short: one byte and three bytes
      frame_buf = '{8'hFF};
      send_frame();
      frame_buf = '{8'h00, 8'hFF, 8'h80};
      send_frame();
      // four bytes, no data: zero CRC passes, anything else is uncorrectable
      frame_buf = '{8'h00, 8'h00, 8'h00, 8'h00};
      send_frame();
      frame_buf = '{8'h00, 8'h00, 8'h00, 8'h80};
      send_frame();
      // one data byte: clean, then its top bit flipped
      build_frame(1);
      frame_buf[0] = 8'hFF;
      build_frame(0);
      frame_buf = '{8'hFF};
      begin
         logic [31:0] c;
         c = crc_frame_scoreboard::crc_steps(CRC_ONES ^ 32'hFF, 8) ^ CRC_ONES;
         frame_buf = '{8'hFF, c[7:0], c[15:8], c[23:16], c[31:24]};
      end
      send_frame();
      flip_bit(0, 7);
      send_frame();
      // two data bytes, lowest bit of the first byte flipped
      build_frame(2);
      flip_bit(0, 0);
      send_frame();

      wait_drained();

      // phase 1: sender idles a third of the time, receiver more than half
      run_random(33, 58, 590);

      wait_drained();

      // phase 2: the other way round
      run_random(58, 33, 590);

      wait_drained();

      // phase 3: no idling at all
      run_random(0, 0, 590);

      wait_drained();
      repeat (40) @(posedge clock);
      if (sb.pending() != 0)
         sb.report_mismatch($sformatf("%0d verdicts never arrived", sb.pending()));
      if (sb.errors == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   // watchdog
   initial begin
      #20_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
